[sv/segment_intersection_param_assert.svh]
// Assertion macros for the segment intersection block.
// Expects i_clk and i_rst_n in the scope where the macros are used.
`ifndef SEGMENT_INTERSECTION_PARAM_ASSERT_SVH
`define SEGMENT_INTERSECTION_PARAM_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SIP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define SIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/sip_pkg.sv]
// Shared types and constants for the segment intersection block.
// No dependencies.
package sip_pkg;

    // Fixed port widths and the sign-extension width
    localparam int IN_W  = 30;
    localparam int OUT_W = 62;
    localparam int EXT_W = 64;

    // Result kind codes
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_POINT = 2'd1,
        KIND_SPAN  = 2'd2
    } t_kind;

    // How a two-product unit combines its products
    typedef enum logic {
        OP_ADD = 1'b0,
        OP_SUB = 1'b1
    } t_comb_op;

endpackage

[sv/sip_dot2.sv]
// Two-stage product pair: registers a*b and c*d, then their sum or difference.
// Depends on sip_pkg.
module sip_dot2 import sip_pkg::*; #(
    parameter int DW = 31
) (
    input  logic                 i_clk,
    input  logic                 i_en_prod,
    input  logic                 i_en_sum,
    input  t_comb_op             i_op,
    input  logic signed [DW-1:0] i_a,
    input  logic signed [DW-1:0] i_b,
    input  logic signed [DW-1:0] i_c,
    input  logic signed [DW-1:0] i_d,
    output logic signed [2*DW:0] o_sum
);

    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    logic signed [PW-1:0] r_ab;
    logic signed [PW-1:0] r_cd;
    logic signed [SW-1:0] r_sum;
    logic signed [SW-1:0] n_sum;

    // Product stage
    always_ff @(posedge i_clk) begin
        if (i_en_prod) begin
            r_ab <= i_a * i_b;
            r_cd <= i_c * i_d;
        end
    end

    // Combine the two products
    always_comb begin
        if (i_op == OP_SUB) begin
            n_sum = SW'(r_ab) - SW'(r_cd);
        end else begin
            n_sum = SW'(r_ab) + SW'(r_cd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

[sv/segment_intersection_param.sv]
// Top level of the segment intersection block: five-stage pipeline.
// Depends on sip_pkg, sip_dot2 and segment_intersection_param_assert.svh.
//
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------------------------
//  input   | i_in_valid / o_in_ready    | i_first_*, i_second_* (start/end x,y)
//  output  | o_out_valid / i_out_ready  | o_hit_kind, o_start_numerator,
//          |                            | o_end_numerator, o_denominator
//
// One pair is taken per cycle while o_in_ready is high; a stall at the output can hold it low.
// Stages: differences, products, product sums, sign fix and ordering, decision.
// The sixteen 31x31 multipliers (at the default COORD_WIDTH), one per product, are all pipelined.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stalled stage holds; a stage whose successor is free or empty advances.
module segment_intersection_param import sip_pkg::*; #(
    parameter int COORD_WIDTH = 30
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [IN_W-1:0]  i_first_start_x,
    input  logic [IN_W-1:0]  i_first_start_y,
    input  logic [IN_W-1:0]  i_first_end_x,
    input  logic [IN_W-1:0]  i_first_end_y,
    input  logic [IN_W-1:0]  i_second_start_x,
    input  logic [IN_W-1:0]  i_second_start_y,
    input  logic [IN_W-1:0]  i_second_end_x,
    input  logic [IN_W-1:0]  i_second_end_y,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_hit_kind,
    output logic [OUT_W-1:0] o_start_numerator,
    output logic [OUT_W-1:0] o_end_numerator,
    output logic [OUT_W-1:0] o_denominator
);

    `include "segment_intersection_param_assert.svh"

    localparam int DW = COORD_WIDTH + 1;
    localparam int SW = 2 * DW + 1;

    // Stage enables and valid bits
    logic en1, en2, en3, en4, en5;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    // Coordinates reduced to COORD_WIDTH bits
    logic signed [COORD_WIDTH-1:0] ax, ay, bx, by, cx, cy, dx, dy;

    // Stage 1: differences
    logic signed [DW-1:0] r1_d1x, r1_d1y, r1_d2x, r1_d2y;
    logic signed [DW-1:0] r1_ox, r1_oy, r1_ex, r1_ey;
    logic r2_ozero, r3_ozero;

    // Stage 3: sums from the product units
    logic signed [SW-1:0] s_det, s_n1, s_n2, s_pa, s_pb, s_m, s_l2, s_q;

    // Stage 4: normalized values and flags
    logic signed [SW-1:0] r4_det, r4_n1, r4_n2, r4_lo, r4_hi, r4_m;
    logic                 r4_coll, r4_coll_ok, r4_on_cd;
    logic signed [SW-1:0] n4_det, n4_n1, n4_n2, n4_lo, n4_hi;
    logic signed [SW:0]   n4_ql2;
    logic                 n4_on_cd;

    // Stage 5: result register
    t_kind             r5_kind;
    logic [OUT_W-1:0]  r5_start, r5_end, r5_den;
    t_kind             n5_kind;
    logic [OUT_W-1:0]  n5_start, n5_end, n5_den;
    logic signed [SW-1:0] n5_endv;
    logic              n5_pt_ok, n5_lo_ok;

    function automatic logic [OUT_W-1:0] to_out(input logic signed [SW-1:0] v);
        logic signed [EXT_W-1:0] e;
        e = EXT_W'(v);
        return e[OUT_W-1:0];
    endfunction

    // Pipeline flow control
    assign en5 = !r_v5 || i_out_ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_in_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // Use only the low COORD_WIDTH bits of each coordinate
    assign ax = i_first_start_x[COORD_WIDTH-1:0];
    assign ay = i_first_start_y[COORD_WIDTH-1:0];
    assign bx = i_first_end_x[COORD_WIDTH-1:0];
    assign by = i_first_end_y[COORD_WIDTH-1:0];
    assign cx = i_second_start_x[COORD_WIDTH-1:0];
    assign cy = i_second_start_y[COORD_WIDTH-1:0];
    assign dx = i_second_end_x[COORD_WIDTH-1:0];
    assign dy = i_second_end_y[COORD_WIDTH-1:0];

    // Stage 1: direction and offset vectors
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_d1x <= DW'(bx) - DW'(ax);
            r1_d1y <= DW'(by) - DW'(ay);
            r1_d2x <= DW'(dx) - DW'(cx);
            r1_d2y <= DW'(dy) - DW'(cy);
            r1_ox  <= DW'(cx) - DW'(ax);
            r1_oy  <= DW'(cy) - DW'(ay);
            r1_ex  <= DW'(dx) - DW'(ax);
            r1_ey  <= DW'(dy) - DW'(ay);
        end
    end

    // Carry the zero-offset flag alongside the product stages
    always_ff @(posedge i_clk) begin
        if (en2) r2_ozero <= (r1_ox == '0) && (r1_oy == '0);
        if (en3) r3_ozero <= r2_ozero;
    end

    // Stages 2 and 3: cross and dot products
    sip_dot2 #(.DW(DW)) u_det (
        .i_clk(i_clk), .i_en_prod(en2), .i_en_sum(en3), .i_op(OP_SUB),
        .i_a(r1_d1x), .i_b(r1_d2y), .i_c(r1_d1y), .i_d(r1_d2x), .o_sum(s_det)
    );
    sip_dot2 #(.DW(DW)) u_n1 (
        .i_clk(i_clk), .i_en_prod(en2), .i_en_sum(en3), .i_op(OP_SUB),
        .i_a(r1_ox), .i_b(r1_d2y), .i_c(r1_oy), .i_d(r1_d2x), .o_sum(s_n1)
    );
    sip_dot2 #(.DW(DW)) u_n2 (
        .i_clk(i_clk), .i_en_prod(en2), .i_en_sum(en3), .i_op(OP_SUB),
        .i_a(r1_ox), .i_b(r1_d1y), .i_c(r1_oy), .i_d(r1_d1x), .o_sum(s_n2)
    );
    sip_dot2 #(.DW(DW)) u_pa (
        .i_clk(i_clk), .i_en_prod(en2), .i_en_sum(en3), .i_op(OP_ADD),
        .i_a(r1_d1x), .i_b(r1_ox), .i_c(r1_d1y), .i_d(r1_oy), .o_sum(s_pa)
    );
    sip_dot2 #(.DW(DW)) u_pb (
        .i_clk(i_clk), .i_en_prod(en2), .i_en_sum(en3), .i_op(OP_ADD),
        .i_a(r1_d1x), .i_b(r1_ex), .i_c(r1_d1y), .i_d(r1_ey), .o_sum(s_pb)
    );
    sip_dot2 #(.DW(DW)) u_m (
        .i_clk(i_clk), .i_en_prod(en2), .i_en_sum(en3), .i_op(OP_ADD),
        .i_a(r1_d1x), .i_b(r1_d1x), .i_c(r1_d1y), .i_d(r1_d1y), .o_sum(s_m)
    );
    sip_dot2 #(.DW(DW)) u_l2 (
        .i_clk(i_clk), .i_en_prod(en2), .i_en_sum(en3), .i_op(OP_ADD),
        .i_a(r1_d2x), .i_b(r1_d2x), .i_c(r1_d2y), .i_d(r1_d2y), .o_sum(s_l2)
    );
    sip_dot2 #(.DW(DW)) u_q (
        .i_clk(i_clk), .i_en_prod(en2), .i_en_sum(en3), .i_op(OP_ADD),
        .i_a(r1_d2x), .i_b(r1_ox), .i_c(r1_d2y), .i_d(r1_oy), .o_sum(s_q)
    );

    // Stage 4: make the determinant non-negative, order the projections, test A on CD
    always_comb begin
        if (s_det < 0) begin
            n4_det = -s_det;
            n4_n1  = -s_n1;
            n4_n2  = -s_n2;
        end else begin
            n4_det = s_det;
            n4_n1  = s_n1;
            n4_n2  = s_n2;
        end
        if (s_pa < s_pb) begin
            n4_lo = s_pa;
            n4_hi = s_pb;
        end else begin
            n4_lo = s_pb;
            n4_hi = s_pa;
        end
        // projection of A onto CD is -q; it must lie in [0, l2]
        n4_ql2 = (SW + 1)'(s_q) + (SW + 1)'(s_l2);
        if (s_l2 == '0) begin
            n4_on_cd = r3_ozero;
        end else begin
            n4_on_cd = (s_q <= 0) && (n4_ql2 >= 0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_det     <= n4_det;
            r4_n1      <= n4_n1;
            r4_n2      <= n4_n2;
            r4_lo      <= n4_lo;
            r4_hi      <= n4_hi;
            r4_m       <= s_m;
            r4_coll    <= (s_det == '0);
            r4_coll_ok <= (s_n1 == '0) && (s_n2 == '0);
            r4_on_cd   <= n4_on_cd;
        end
    end

    // Stage 5: pick the result
    always_comb begin
        n5_endv  = (r4_hi < r4_m) ? r4_hi : r4_m;
        n5_pt_ok = (r4_n1 >= 0) && (r4_n2 >= 0) && (r4_n1 <= r4_det) && (r4_n2 <= r4_det);
        n5_lo_ok = (r4_lo > 0) && (r4_lo <= r4_m);
        n5_kind  = KIND_NONE;
        n5_start = '0;
        n5_end   = '0;
        n5_den   = '0;
        if (r4_coll) begin
            if (r4_coll_ok && (r4_on_cd || n5_lo_ok)) begin
                n5_kind  = KIND_SPAN;
                n5_start = r4_on_cd ? '0 : to_out(r4_lo);
                n5_end   = to_out(n5_endv);
                n5_den   = to_out(r4_m);
            end
        end else if (n5_pt_ok) begin
            n5_kind  = KIND_POINT;
            n5_start = to_out(r4_n1);
            n5_end   = to_out(r4_n1);
            n5_den   = to_out(r4_det);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_kind  <= n5_kind;
            r5_start <= n5_start;
            r5_end   <= n5_end;
            r5_den   <= n5_den;
        end
    end

    assign o_out_valid       = r_v5;
    assign o_hit_kind        = r5_kind;
    assign o_start_numerator = r5_start;
    assign o_end_numerator   = r5_end;
    assign o_denominator     = r5_den;

    // Checks
    `SIP_ASSERT_NOW(a_none_zero, r_v5 && (r5_kind == KIND_NONE),
        (r5_start == '0) && (r5_end == '0) && (r5_den == '0), "miss carries nonzero fields")
    `SIP_ASSERT_NOW(a_point_form, r_v5 && (r5_kind == KIND_POINT),
        (r5_start == r5_end) && (r5_start <= r5_den), "point fraction out of range")
    `SIP_ASSERT_NEXT(a_in_enters, i_in_valid && o_in_ready, r_v1, "transfer did not enter stage 1")
    `SIP_ASSERT_NEXT(a_stall_holds, r_v4 && !en4, r_v4 && $stable(r4_det) && $stable(r4_lo),
        "stalled stage 4 lost its item")

endmodule
